@@ rtl/scrd_pkg.sv @@
// ----------------------------------------------------------------------------
// scrd_pkg
// Types and constants shared by the spherical camera ray direction pipeline.
// ----------------------------------------------------------------------------
package scrd_pkg;

  localparam int CW           = 34;
  localparam int MAG_W        = 62;
  localparam int REDUCE_STEPS = 16;
  localparam int BASIS_W      = 21;
  localparam int OUT_W        = 24;

  localparam logic [47:0] TWO_PI_Q44 = 48'h6487ED5110B4;
  localparam logic [47:0] PI_Q44     = 48'h3243F6A8885A;

  localparam logic signed [CW-1:0] PI_Q30       = 34'sh0C90FDAA2;
  localparam logic signed [CW-1:0] HALF_PI_Q30  = 34'sh06487ED51;
  localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sh026DD3B6A;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

  localparam logic [2:0] REG_X_SCALE = 3'd0;
  localparam logic [2:0] REG_Y_SCALE = 3'd1;
  localparam logic [2:0] REG_BASIS_U = 3'd2;
  localparam logic [2:0] REG_BASIS_V = 3'd3;
  localparam logic [2:0] REG_BASIS_W = 3'd4;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [CW-1:0] z;
    logic                 flip;
  } angle_t;

  typedef struct packed {
    logic signed [CW-1:0] s;
    logic signed [CW-1:0] c;
  } sincos_t;

endpackage

@@ rtl/scrd_angle.sv @@
// ----------------------------------------------------------------------------
// scrd_angle
// Scales a view-plane coordinate to an angle, reduces it modulo two pi by
// conditional subtraction, wraps it and folds it into the CORDIC range.
// ----------------------------------------------------------------------------
module scrd_angle (
  input  logic                clk,
  input  logic                en,
  input  logic signed [31:0]  point,
  input  logic [30:0]         scale,
  output scrd_pkg::angle_t    angle
);

  localparam int N = scrd_pkg::REDUCE_STEPS;

  logic signed [62:0]            prod_r;
  logic [scrd_pkg::MAG_W-1:0]    mag_r [N+1];
  logic                          neg_r [N+1];
  logic signed [scrd_pkg::CW-1:0] zw_r;
  scrd_pkg::angle_t              ang_r;

  logic signed [63:0] prod_nxt;
  assign prod_nxt = point * $signed({1'b0, scale});

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= prod_nxt[62:0];
      neg_r[0] <= prod_r[62];
      mag_r[0] <= prod_r[62] ? scrd_pkg::MAG_W'(-prod_r) : scrd_pkg::MAG_W'(prod_r);
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_reduce
    localparam logic [scrd_pkg::MAG_W-1:0] SUB =
      scrd_pkg::MAG_W'(scrd_pkg::TWO_PI_Q44) << (N - 1 - k);
    always_ff @(posedge clk) begin
      if (en) begin
        mag_r[k+1] <= (mag_r[k] >= SUB) ? mag_r[k] - SUB : mag_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  logic [47:0]        rem;
  logic signed [48:0] wrap;
  logic signed [48:0] wrap_s;
  logic signed [48:0] wrap_sh;

  always_comb begin
    rem     = mag_r[N][47:0];
    wrap    = (rem > scrd_pkg::PI_Q44) ?
              $signed({1'b0, rem}) - $signed({1'b0, scrd_pkg::TWO_PI_Q44}) :
              $signed({1'b0, rem});
    wrap_s  = neg_r[N] ? -wrap : wrap;
    wrap_sh = wrap_s >>> 14;
  end

  scrd_pkg::angle_t ang_nxt;

  always_comb begin
    ang_nxt.z    = zw_r;
    ang_nxt.flip = 1'b0;
    if (zw_r > scrd_pkg::HALF_PI_Q30) begin
      ang_nxt.z    = zw_r - scrd_pkg::PI_Q30;
      ang_nxt.flip = 1'b1;
    end else if (zw_r < -scrd_pkg::HALF_PI_Q30) begin
      ang_nxt.z    = zw_r + scrd_pkg::PI_Q30;
      ang_nxt.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zw_r  <= wrap_sh[scrd_pkg::CW-1:0];
      ang_r <= ang_nxt;
    end
  end

  assign angle = ang_r;

endmodule

@@ rtl/scrd_cordic.sv @@
// ----------------------------------------------------------------------------
// scrd_cordic
// Unrolled rotation-mode CORDIC, one register stage per iteration, giving
// sine and cosine in Q.30 with the quadrant fold undone at the output.
// ----------------------------------------------------------------------------
module scrd_cordic #(
  parameter int STAGES = 20
) (
  input  logic              clk,
  input  logic              en,
  input  scrd_pkg::angle_t  angle,
  output scrd_pkg::sincos_t sc
);

  logic signed [scrd_pkg::CW-1:0] x_r [STAGES+1];
  logic signed [scrd_pkg::CW-1:0] y_r [STAGES+1];
  logic signed [scrd_pkg::CW-1:0] z_r [STAGES+1];
  logic                           flip_r [STAGES+1];

  assign x_r[0]    = scrd_pkg::INV_GAIN_Q30;
  assign y_r[0]    = '0;
  assign z_r[0]    = angle.z;
  assign flip_r[0] = angle.flip;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [scrd_pkg::CW-1:0] ATAN =
      $signed({2'b00, scrd_pkg::ATAN_Q30[i]});
    logic signed [scrd_pkg::CW-1:0] dx;
    logic signed [scrd_pkg::CW-1:0] dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ATAN;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ATAN;
        end
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  logic unused_z;
  assign unused_z = ^z_r[STAGES];

  assign sc.s = flip_r[STAGES] ? -y_r[STAGES] : y_r[STAGES];
  assign sc.c = flip_r[STAGES] ? -x_r[STAGES] : x_r[STAGES];

endmodule

@@ rtl/scrd_combine.sv @@
// ----------------------------------------------------------------------------
// scrd_combine
// Forms the three direction coefficients, projects them on the camera basis
// and rounds and saturates each component to Q3.20.
// ----------------------------------------------------------------------------
module scrd_combine (
  input  logic                               clk,
  input  logic                               en,
  input  scrd_pkg::sincos_t                  lam,
  input  scrd_pkg::sincos_t                  psi,
  input  logic [62:0]                        basis_u,
  input  logic [62:0]                        basis_v,
  input  logic [62:0]                        basis_w,
  output logic signed [scrd_pkg::OUT_W-1:0]  dir [3]
);

  localparam int CW = scrd_pkg::CW;
  localparam int BW = scrd_pkg::BASIS_W;
  localparam int PW = CW + BW;

  logic signed [2*CW-1:0] pa;
  logic signed [2*CW-1:0] pc;
  logic signed [CW-1:0]   a_r, b_r, c_r;

  assign pa = psi.c * lam.s;
  assign pc = psi.c * lam.c;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= pa[CW+29:30];
      b_r <= psi.s;
      c_r <= -pc[CW+29:30];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_comp
    logic signed [BW-1:0] bu, bv, bw;
    logic signed [PW-1:0] pu_r, pv_r, pw_r;
    logic signed [PW+1:0] acc;
    logic signed [PW-28:0] q;
    logic signed [scrd_pkg::OUT_W-1:0] dir_r;

    assign bu = $signed(basis_u[BW*k +: BW]);
    assign bv = $signed(basis_v[BW*k +: BW]);
    assign bw = $signed(basis_w[BW*k +: BW]);

    always_comb begin
      acc = (PW+2)'(pu_r) + (PW+2)'(pv_r) + (PW+2)'(pw_r) + (PW+2)'(1 << 28);
      q   = acc[PW+1:29];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pu_r <= a_r * bu;
        pv_r <= b_r * bv;
        pw_r <= c_r * bw;
        if (q > (PW-27)'(scrd_pkg::OUT_MAX)) begin
          dir_r <= scrd_pkg::OUT_MAX;
        end else if (q < (PW-27)'(scrd_pkg::OUT_MIN)) begin
          dir_r <= scrd_pkg::OUT_MIN;
        end else begin
          dir_r <= q[scrd_pkg::OUT_W-1:0];
        end
      end
    end

    assign dir[k] = dir_r;
  end

endmodule

@@ rtl/spherical_camera_ray_direction.sv @@
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while a finished result waits on out_ready.
// Reset clears the pipeline valid bits and all configuration registers.
// Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
// spherical_camera_ray_direction
// Spherical panoramic camera ray generation: two angle reduction paths, two
// CORDIC pipelines and a basis projection with saturation.
// ----------------------------------------------------------------------------
module spherical_camera_ray_direction #(
  parameter int CORDIC_STAGES = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_dir_x,
  output logic signed [23:0] out_dir_y,
  output logic signed [23:0] out_dir_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam int LAT = CORDIC_STAGES + 23;

  logic [30:0] x_scale_r, y_scale_r;
  logic [62:0] basis_u_r, basis_v_r, basis_w_r;
  logic [LAT-1:0] vld_r;
  logic en;

  assign cfg_ready = 1'b1;
  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_scale_r <= '0;
      y_scale_r <= '0;
      basis_u_r <= '0;
      basis_v_r <= '0;
      basis_w_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        scrd_pkg::REG_X_SCALE: x_scale_r <= cfg_data[30:0];
        scrd_pkg::REG_Y_SCALE: y_scale_r <= cfg_data[30:0];
        scrd_pkg::REG_BASIS_U: basis_u_r <= cfg_data[62:0];
        scrd_pkg::REG_BASIS_V: basis_v_r <= cfg_data[62:0];
        scrd_pkg::REG_BASIS_W: basis_w_r <= cfg_data[62:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  scrd_pkg::angle_t  lam_ang, psi_ang;
  scrd_pkg::sincos_t lam_sc, psi_sc;
  logic signed [23:0] dir [3];

  scrd_angle u_lam_angle (.clk(clk), .en(en), .point(in_point_x), .scale(x_scale_r),
                          .angle(lam_ang));
  scrd_angle u_psi_angle (.clk(clk), .en(en), .point(in_point_y), .scale(y_scale_r),
                          .angle(psi_ang));

  scrd_cordic #(.STAGES(CORDIC_STAGES)) u_lam_cordic (
    .clk(clk), .en(en), .angle(lam_ang), .sc(lam_sc)
  );
  scrd_cordic #(.STAGES(CORDIC_STAGES)) u_psi_cordic (
    .clk(clk), .en(en), .angle(psi_ang), .sc(psi_sc)
  );

  scrd_combine u_combine (
    .clk(clk), .en(en), .lam(lam_sc), .psi(psi_sc),
    .basis_u(basis_u_r), .basis_v(basis_v_r), .basis_w(basis_w_r), .dir(dir)
  );

  assign out_dir_x = dir[0];
  assign out_dir_y = dir[1];
  assign out_dir_z = dir[2];

`ifndef SYNTH
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(vld_r)) else $error("pipeline moved during stall");
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0]) else $error("accepted item lost");
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("stall without waiting result");
`endif

endmodule

@@ tb/sv/spherical_camera_ray_direction_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_camera_ray_direction_tb
// Drives view-plane sample points through the ray direction pipeline under
// several angle scales and camera bases, and checks every direction against a
// bit-exact fixed-point model of the angle reduction, CORDIC and projection.
// ----------------------------------------------------------------------------
module spherical_camera_ray_direction_tb;

  localparam int STAGES = 20;
  localparam int LATENCY = STAGES + 23;
  localparam int WATCHDOG = 20000;
  localparam logic signed [63:0] TWO_PI = 64'sh6487ED5110B4;
  localparam logic signed [63:0] PI_ANGLE = 64'sh3243F6A8885A;
  localparam logic [2:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } dir_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] out_dir_x, out_dir_y, out_dir_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [30:0] scale_x, scale_y;
  logic [62:0] axis_u, axis_v, axis_w;
  dir_t pending_dirs[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;

  spherical_camera_ray_direction #(.CORDIC_STAGES(STAGES)) dut (.*);

  always #5 clk = ~clk;

  function automatic logic signed [63:0] fshift(logic signed [63:0] v, int n);
    return v >>> n;
  endfunction

  function automatic void angle_sin_cos(logic signed [63:0] a,
                                        output logic signed [63:0] s,
                                        output logic signed [63:0] c);
    logic signed [63:0] r, x, y, z, dx, dy;
    bit flip;
    r = a % TWO_PI;
    x = 64'sh26DD3B6A;
    y = '0;
    flip = 1'b0;
    if (r > PI_ANGLE) r -= TWO_PI;
    else if (r < -PI_ANGLE) r += TWO_PI;
    z = fshift(r, 14);
    if (z > 64'sh6487ED51) begin
      z -= 64'shC90FDAA2;
      flip = 1'b1;
    end else if (z < -64'sh6487ED51) begin
      z += 64'shC90FDAA2;
      flip = 1'b1;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= $signed({32'd0, scrd_pkg::ATAN_Q30[i]});
      end else begin
        x += dx;
        y -= dy;
        z += $signed({32'd0, scrd_pkg::ATAN_Q30[i]});
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic logic signed [23:0] project(int sh, logic signed [63:0] a,
                                                 logic signed [63:0] b,
                                                 logic signed [63:0] c);
    logic signed [63:0] acc, q;
    logic signed [20:0] bu, bv, bw;
    bu = axis_u[sh +: 21];
    bv = axis_v[sh +: 21];
    bw = axis_w[sh +: 21];
    acc = a * bu + b * bv + c * bw;
    q = fshift(acc + (64'sd1 <<< 28), 29);
    if (q > 64'sd8388607) q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;
    return q[23:0];
  endfunction

  function automatic dir_t expected_dir(logic signed [31:0] px,
                                        logic signed [31:0] py);
    logic signed [63:0] sl, cl, sp, cp, a, b, c;
    dir_t d;
    angle_sin_cos(64'(px) * $signed({33'd0, scale_x}), sl, cl);
    angle_sin_cos(64'(py) * $signed({33'd0, scale_y}), sp, cp);
    a = fshift(cp * sl, 30);
    b = sp;
    c = -fshift(cp * cl, 30);
    d.x = project(0, a, b, c);
    d.y = project(21, a, b, c);
    d.z = project(42, a, b, c);
    return d;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      scrd_pkg::REG_X_SCALE: scale_x = value[30:0];
      scrd_pkg::REG_Y_SCALE: scale_y = value[30:0];
      scrd_pkg::REG_BASIS_U: axis_u = value[62:0];
      scrd_pkg::REG_BASIS_V: axis_v = value[62:0];
      scrd_pkg::REG_BASIS_W: axis_w = value[62:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_point(logic signed [31:0] px, logic signed [31:0] py);
    while (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    do @(posedge clk); while (!in_ready);
    pending_dirs.push_back(expected_dir(px, py));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_dirs.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [62:0] rand_basis();
    return 63'({$urandom(), $urandom()});
  endfunction

  function automatic logic [62:0] unit_basis(int comp, bit neg);
    logic [62:0] b;
    b = '0;
    b[comp*21 +: 21] = neg ? 21'h180000 : 21'h080000;
    return b;
  endfunction

  always @(posedge clk) begin
    if (!rst_n || hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin
    dir_t exp_d;
    if (rst_n && out_valid && out_ready) begin
      if (pending_dirs.size() == 0) begin
        $display("%0t: unexpected direction %h %h %h", $time,
                 out_dir_x, out_dir_y, out_dir_z);
        errors++;
      end else begin
        exp_d = pending_dirs.pop_front();
        if (out_dir_x !== exp_d.x) begin
          $display("%0t: dir_x expected %h actual %h", $time, exp_d.x, out_dir_x);
          errors++;
        end
        if (out_dir_y !== exp_d.y) begin
          $display("%0t: dir_y expected %h actual %h", $time, exp_d.y, out_dir_y);
          errors++;
        end
        if (out_dir_z !== exp_d.z) begin
          $display("%0t: dir_z expected %h actual %h", $time, exp_d.z, out_dir_z);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
  } point_row_t;

  point_row_t directed[] = '{
    '{32'sh00000000, 32'sh00000000}, '{32'sh7FFFFFFF, 32'sh7FFFFFFF},
    '{32'sh80000000, 32'sh80000000}, '{32'sh7FFFFFFF, 32'sh80000000},
    '{32'shFFFFFFFF, 32'sh00000001}, '{32'sh00010000, 32'shFFFF0000},
    '{32'sh00020000, 32'sh00030000}, '{32'shFFFD0000, 32'sh00018000},
    '{32'sh00008000, 32'shFFFF8000}, '{32'sh55555555, 32'shAAAAAAAA},
    '{32'sh00040000, 32'shFFFC0000}, '{32'sh0000C000, 32'sh00002000}
  };

  initial begin
    logic signed [31:0] px, py;
    scale_x = '0; scale_y = '0; axis_u = '0; axis_v = '0; axis_w = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset every configuration register is zero, so the direction is zero.
    send_point(32'sh12345678, 32'sh87654321);
    drain();

    // Identity basis with w negated makes the output a and b and the negated c coefficient.
    write_reg(scrd_pkg::REG_BASIS_U, unit_basis(0, 0));
    write_reg(scrd_pkg::REG_BASIS_V, unit_basis(1, 0));
    write_reg(scrd_pkg::REG_BASIS_W, unit_basis(2, 1));
    write_reg(scrd_pkg::REG_X_SCALE, 64'h0000_0000_1000_0000);
    write_reg(scrd_pkg::REG_Y_SCALE, 64'hFFFF_FFFF_0800_0000);
    write_reg(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
    foreach (directed[i]) send_point(directed[i].px, directed[i].py);
    drain();

    // Largest scales, and bases with all-ones, largest positive and most negative fields.
    write_reg(scrd_pkg::REG_X_SCALE, 64'h7FFF_FFFF);
    write_reg(scrd_pkg::REG_Y_SCALE, 64'h7FFF_FFFF);
    write_reg(scrd_pkg::REG_BASIS_U, 64'h7FFF_FFFF_FFFF_FFFF);
    write_reg(scrd_pkg::REG_BASIS_V, {1'b0, 21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF});
    write_reg(scrd_pkg::REG_BASIS_W, {1'b0, 21'h100000, 21'h100000, 21'h100000});
    foreach (directed[i]) send_point(directed[i].px, directed[i].py);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      quiet = (phase == 3);
      case (phase % 4)
        0: write_reg(scrd_pkg::REG_X_SCALE, 64'($urandom_range(32'h0100_0000)));
        1: write_reg(scrd_pkg::REG_X_SCALE, {$urandom(), $urandom()});
        2: write_reg(scrd_pkg::REG_X_SCALE, 64'd0);
        default: write_reg(scrd_pkg::REG_X_SCALE, 64'h7FFF_FFFF);
      endcase
      write_reg(scrd_pkg::REG_Y_SCALE, (phase % 2) ? {$urandom(), $urandom()} :
                                       64'($urandom_range(32'h0080_0000)));
      write_reg(scrd_pkg::REG_BASIS_U, rand_basis());
      write_reg(scrd_pkg::REG_BASIS_V, rand_basis());
      write_reg(scrd_pkg::REG_BASIS_W, rand_basis());
      if (phase == 5) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (200) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(3) == 0) begin
          px = $urandom();
          py = $urandom();
        end else begin
          px = $signed(32'($urandom_range(32'h0008_0000))) - 32'sh0004_0000;
          py = $signed(32'($urandom_range(32'h0008_0000))) - 32'sh0004_0000;
        end
        send_point(px, py);
      end
      drain();
    end
    quiet = 1'b0;

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
